[rtl/awa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awa_pkg: shared definitions for the adaptive window average alarm
// Field widths, register indexes, class and action codes, the action table.
// ----------------------------------------------------------------------------
package awa_pkg;

	// field widths
	localparam int SMP_W     = 12;
	localparam int LIM_W     = 12;
	localparam int MODE_W    = 2;
	localparam int WSZ_W     = 5;
	localparam int CLS_W     = 2;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_LIM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_LIM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_MODE   = 2'd3;

	// register reset values
	localparam logic [LIM_W-1:0]  CHANGE_THR_RST = 12'd200;
	localparam logic [LIM_W-1:0]  WARN_LIM_RST   = 12'd372;
	localparam logic [LIM_W-1:0]  DANGER_LIM_RST = 12'd496;

	// system modes
	localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SAFE   = 2'd2;

	// sensor classes
	localparam logic [CLS_W-1:0]  CLS_NORMAL   = 2'd0;
	localparam logic [CLS_W-1:0]  CLS_WARNING  = 2'd1;
	localparam logic [CLS_W-1:0]  CLS_DANGER   = 2'd2;
	localparam logic [CLS_W-1:0]  CLS_RESERVED = 2'd3;

	// action codes
	localparam logic [ACT_W-1:0]  DRIVE_NORMAL  = 2'd0;
	localparam logic [ACT_W-1:0]  DRIVE_WARNING = 2'd1;
	localparam logic [ACT_W-1:0]  DRIVE_DANGER  = 2'd2;
	localparam logic [ACT_W-1:0]  DRIVE_IDLE    = 2'd3;

	// configuration register set
	typedef struct packed {
		logic [LIM_W-1:0]  change_thr;
		logic [LIM_W-1:0]  warn_lim;
		logic [LIM_W-1:0]  danger_lim;
		logic [MODE_W-1:0] op_mode;
	} cfg_regs_t;

	// action by class and mode; safe and the unused mode code idle everything
	function automatic logic [ACT_W-1:0] action_lookup(input logic [CLS_W-1:0] cls,
			input logic [MODE_W-1:0] mode);
		logic [ACT_W-1:0] act;
		act = DRIVE_IDLE;
		if (mode == MODE_AUTO || mode == MODE_MANUAL) begin
			case (cls)
				CLS_NORMAL:  act = DRIVE_NORMAL;
				CLS_WARNING: act = DRIVE_WARNING;
				CLS_DANGER:  act = (mode == MODE_AUTO) ? DRIVE_DANGER : DRIVE_WARNING;
				default:     act = DRIVE_IDLE;
			endcase
		end
		return act;
	endfunction

endpackage

[rtl/awa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awa_if: channel interfaces of the adaptive window average alarm
// Sample request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface awa_smp_if
	import awa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface awa_res_if
	import awa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] filtered;
	logic [WSZ_W-1:0] window_size;
	logic [CLS_W-1:0] sensor_class;
	logic [ACT_W-1:0] action_code;
	logic             red_led;
	logic             green_led;
	logic             relay_on;

	modport source (output valid, output filtered, output window_size, output sensor_class,
		output action_code, output red_led, output green_led, output relay_on, input ready);
	modport sink   (input valid, input filtered, input window_size, input sensor_class,
		input action_code, input red_led, input green_led, input relay_on, output ready);
endinterface

interface awa_cfg_if
	import awa_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/adaptive_window_average_alarm_top.sv]
`timescale 1ns / 1ps
// A result is registered after its sample request is taken: the history shift, the
//   divide and the result load run in turn (SHIFT, DIV, DONE states).
// A new sample is taken only in the idle state, after the last result is loaded; the history shift uses one
//   memory read and one write per cycle, then the shared adder divides one bit a cycle.
// Reset clears the sequencer, the previous sample, the history valid bits (history
//   reads as zero) and restores the register defaults.
// ----------------------------------------------------------------------------
// adaptive_window_average_alarm_top: adaptive window moving average with alarm
// Picks a short or long window from the sample step, shifts the history in a
// memory, sums and divides with one shared adder, then classes the mean.
// ----------------------------------------------------------------------------
module adaptive_window_average_alarm_top
	import awa_pkg::*;
#(
	parameter int LONG_WINDOW  = 16,
	parameter int SHORT_WINDOW = 2,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	awa_smp_if.sink   smp,
	awa_res_if.source res,
	awa_cfg_if.sink   cfg
);

	localparam int SW        = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
	localparam int SHORT_EFF = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
	localparam int IDX_W     = $clog2(LONG_WINDOW);
	localparam int WIN_W     = $clog2(LONG_WINDOW + 1);
	localparam int SUM_W     = SW + IDX_W;
	localparam int CNT_W     = $clog2(SW);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SHIFT = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	cfg_regs_t         regs_q;
	logic [1:0]        state_q;
	logic [SW-1:0]     smp_q;
	logic [SW-1:0]     last_q;
	logic [WIN_W-1:0]  win_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  wr_addr_q;
	logic              pend_q;
	logic [SUM_W-1:0]  sum_q;
	logic [WIN_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SW-1:0]     rd_data_q;
	logic              rd_vld_q;
	logic [LONG_WINDOW-1:0] valid_q;
	logic [SW-1:0]     hist_mem [LONG_WINDOW];

	logic              out_vld_q;
	logic [SMP_W-1:0]  filt_q;
	logic [WSZ_W-1:0]  wsz_q;
	logic [CLS_W-1:0]  cls_q;
	logic [ACT_W-1:0]  act_q;

	logic              smp_acc;
	logic [SW-1:0]     smp_in;
	logic [SW-1:0]     delta;
	logic [WIN_W-1:0]  win_sel;
	logic              issue;
	logic              front;
	logic [IDX_W-1:0]  rd_addr;
	logic [SW-1:0]     pend_data;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [SW-1:0]     mem_wdata;
	logic [WIN_W:0]    trial;
	logic [SUM_W-1:0]  alu_a;
	logic [SUM_W-1:0]  alu_b;
	logic              alu_cin;
	logic [SUM_W:0]    alu_res;
	logic              ge;
	logic [SMP_W-1:0]  mean;
	logic [CLS_W-1:0]  cls_d;
	logic              load_out;
	logic [31:0]       win_wide;

	// handshakes
	assign smp.ready = (state_q == S_IDLE);
	assign smp_acc   = smp.valid && smp.ready;
	assign cfg.ready = 1'b1;

	// window choice from the step against the previous sample
	assign smp_in  = smp.sample[SW-1:0];
	assign delta   = (smp_in > last_q) ? (smp_in - last_q) : (last_q - smp_in);
	assign win_sel = (SMP_W'(delta) > regs_q.change_thr) ? WIN_W'(SHORT_EFF)
		: WIN_W'(LONG_WINDOW);

	// history shift: read entry idx-1 now, write it to idx next cycle
	assign issue     = (state_q == S_SHIFT) && (idx_q != '0);
	assign front     = (state_q == S_SHIFT) && !issue && !pend_q;
	assign rd_addr   = idx_q - IDX_W'(1);
	assign pend_data = rd_vld_q ? rd_data_q : '0;
	assign mem_we    = (state_q == S_SHIFT) && (pend_q || front);
	assign mem_waddr = pend_q ? wr_addr_q : '0;
	assign mem_wdata = pend_q ? pend_data : smp_q;

	// shared adder: accumulate during the shift, trial subtract during the divide
	assign trial = {rem_q, sum_q[SW-1]};
	always_comb begin
		if (state_q == S_DIV) begin
			alu_a   = SUM_W'(trial);
			alu_b   = ~SUM_W'(win_q);
			alu_cin = 1'b1;
		end else begin
			alu_a   = sum_q;
			alu_b   = SUM_W'(pend_data);
			alu_cin = 1'b0;
		end
	end
	assign alu_res = {1'b0, alu_a} + {1'b0, alu_b} + (SUM_W + 1)'(alu_cin);
	assign ge      = alu_res[SUM_W];

	// classification of the finished mean
	assign mean  = SMP_W'(sum_q[SW-1:0]);
	assign cls_d = (mean < regs_q.warn_lim) ? CLS_NORMAL
		: ((mean < regs_q.danger_lim) ? CLS_WARNING : CLS_DANGER);
	assign load_out = (state_q == S_DONE) && (!out_vld_q || res.ready);
	assign win_wide = 32'(win_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.change_thr <= CHANGE_THR_RST;
			regs_q.warn_lim   <= WARN_LIM_RST;
			regs_q.danger_lim <= DANGER_LIM_RST;
			regs_q.op_mode    <= MODE_AUTO;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CHANGE_THR: regs_q.change_thr <= cfg.data;
				REG_WARN_LIM:   regs_q.warn_lim   <= cfg.data;
				REG_DANGER_LIM: regs_q.danger_lim <= cfg.data;
				REG_SYS_MODE:   regs_q.op_mode    <= cfg.data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// history memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= hist_mem[rd_addr];
	end

	// entry valid bits; an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (smp_acc) begin
						last_q  <= smp_in;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					pend_q <= issue;
					if (front) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (smp_acc) begin
					smp_q <= smp_in;
					win_q <= win_sel;
					idx_q <= IDX_W'(win_sel - WIN_W'(1));
					sum_q <= SUM_W'(smp_in);
				end
			end
			S_SHIFT: begin
				if (issue) begin
					wr_addr_q <= idx_q;
					idx_q     <= idx_q - IDX_W'(1);
				end
				if (pend_q) begin
					sum_q <= alu_res[SUM_W-1:0];
				end
				if (front) begin
					rem_q <= WIN_W'(sum_q[SUM_W-1:SW]);
					cnt_q <= CNT_W'(SW - 1);
				end
			end
			S_DIV: begin
				rem_q           <= ge ? alu_res[WIN_W-1:0] : trial[WIN_W-1:0];
				sum_q[SW-1:0]   <= {sum_q[SW-2:0], ge};
				cnt_q           <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filt_q <= mean;
			wsz_q  <= win_wide[WSZ_W-1:0];
			cls_q  <= cls_d;
			act_q  <= action_lookup(cls_d, regs_q.op_mode);
		end
	end

	assign res.valid        = out_vld_q;
	assign res.filtered     = filt_q;
	assign res.window_size  = wsz_q;
	assign res.sensor_class = cls_q;
	assign res.action_code  = act_q;
	assign res.red_led      = (act_q == DRIVE_WARNING) || (act_q == DRIVE_DANGER);
	assign res.green_led    = (act_q == DRIVE_NORMAL);
	assign res.relay_on     = (act_q == DRIVE_DANGER);

`ifndef SYNTHESIS
	a_acc_starts_shift: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> (state_q == S_SHIFT))
		else $error("accepted sample did not start the shift");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && issue) |-> (mem_waddr != rd_addr))
		else $error("history write hits the entry being read");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (res.valid && state_q == S_IDLE))
		else $error("finished result not presented");

	a_win_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (win_q == WIN_W'(SHORT_EFF) || win_q == WIN_W'(LONG_WINDOW)))
		else $error("window length is neither short nor long");

	a_cls_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.sensor_class != CLS_RESERVED))
		else $error("reserved sensor class on result");
`endif

endmodule

[test/tb_adaptive_window_average_alarm_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_window_average_alarm_top: self-checking bench for the alarm filter
// A table of directed requests, then random sample streams under several
// register settings. Both channels stall at random. Each result is checked
// field by field against an in-bench model of the adaptive window mean,
// its class and the lamp and relay action.
// ----------------------------------------------------------------------------
module tb_adaptive_window_average_alarm_top;
	import awa_pkg::*;

	localparam int LONG_WIN  = 16;
	localparam int SHORT_WIN = 2;
	localparam int CLK_HALF  = 10;

	// the mode code left unused by the package; behaves like safe
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [SMP_W-1:0] filtered;
		logic [WSZ_W-1:0] window_size;
		logic [CLS_W-1:0] sensor_class;
		logic [ACT_W-1:0] action_code;
		logic             red_led;
		logic             green_led;
		logic             relay_on;
	} alarm_result_t;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] value;
		bit                   typed;
		alarm_result_t        want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	awa_smp_if smp_ch ();
	awa_res_if res_ch ();
	awa_cfg_if cfg_ch ();

	adaptive_window_average_alarm_top #(
		.LONG_WINDOW (LONG_WIN),
		.SHORT_WINDOW(SHORT_WIN),
		.SAMPLE_BITS (SMP_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.smp   (smp_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// model state and register copy
	logic [SMP_W-1:0]  model_last;
	logic [SMP_W-1:0]  history [LONG_WIN];
	logic [LIM_W-1:0]  thr_reg;
	logic [LIM_W-1:0]  warn_reg;
	logic [LIM_W-1:0]  danger_reg;
	logic [MODE_W-1:0] mode_reg;

	alarm_result_t pending_alarms [$];
	stim_row_t     directed_rows [$];
	int            mismatch_cnt;
	int            tx_idle_pct;
	int            rx_idle_pct;

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// result channel back-pressure
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// adaptive window mean, class and action for one sample; advances the model
	function automatic alarm_result_t predict_alarm(input logic [SMP_W-1:0] s);
		alarm_result_t r;
		int unsigned   step;
		int unsigned   win;
		int unsigned   sum;
		step = (s > model_last) ? 32'(s - model_last) : 32'(model_last - s);
		model_last = s;
		win = (step > thr_reg) ? SHORT_WIN : LONG_WIN;
		for (int i = win - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = s;
		sum = 0;
		for (int i = 0; i < win; i++)
			sum += 32'(history[i]);
		r.filtered    = SMP_W'(sum / win);
		r.window_size = WSZ_W'(win);
		if (r.filtered < warn_reg)
			r.sensor_class = CLS_NORMAL;
		else if (r.filtered < danger_reg)
			r.sensor_class = CLS_WARNING;
		else
			r.sensor_class = CLS_DANGER;
		// manual caps danger at warning; safe and the unused code go idle
		case (mode_reg)
			MODE_AUTO: begin
				r.action_code = (r.sensor_class == CLS_DANGER) ? DRIVE_DANGER :
					(r.sensor_class == CLS_WARNING) ? DRIVE_WARNING : DRIVE_NORMAL;
			end
			MODE_MANUAL: begin
				r.action_code = (r.sensor_class == CLS_NORMAL) ? DRIVE_NORMAL : DRIVE_WARNING;
			end
			default: r.action_code = DRIVE_IDLE;
		endcase
		r.red_led   = (r.action_code == DRIVE_WARNING || r.action_code == DRIVE_DANGER);
		r.green_led = (r.action_code == DRIVE_NORMAL);
		r.relay_on  = (r.action_code == DRIVE_DANGER);
		return r;
	endfunction

	function automatic void check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatch_cnt++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		alarm_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_alarms.size() == 0) begin
				$error("result request with no expected result pending");
				mismatch_cnt++;
			end else begin
				want = pending_alarms.pop_front();
				check_field("filtered", 32'(want.filtered), 32'(res_ch.filtered));
				check_field("window_size", 32'(want.window_size), 32'(res_ch.window_size));
				check_field("sensor_class", 32'(want.sensor_class),
					32'(res_ch.sensor_class));
				check_field("action_code", 32'(want.action_code), 32'(res_ch.action_code));
				check_field("red_led", 32'(want.red_led), 32'(res_ch.red_led));
				check_field("green_led", 32'(want.green_led), 32'(res_ch.green_led));
				check_field("relay_on", 32'(want.relay_on), 32'(res_ch.relay_on));
			end
		end
	end

	// one sample request; idle gaps drop valid first
	task automatic send_sample(input logic [SMP_W-1:0] s, input bit typed,
			input alarm_result_t typed_want);
		alarm_result_t r;
		int            gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (tx_idle_pct > 0 && $urandom_range(7) == 0)
			gap += $urandom_range(1, 40);
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid  <= 1'b1;
		smp_ch.sample <= s;
		do @(posedge clk); while (!smp_ch.ready);
		r = predict_alarm(s);
		pending_alarms.push_back(typed ? typed_want : r);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		smp_ch.valid <= 1'b0;
		while (pending_alarms.size() != 0)
			@(posedge clk);
	endtask

	// register write; only issued with no request in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_CHANGE_THR: thr_reg    = val;
			REG_WARN_LIM:   warn_reg   = val;
			REG_DANGER_LIM: danger_reg = val;
			default:        mode_reg   = val[MODE_W-1:0];
		endcase
		// idle before the next request so it starts on a fresh edge
		@(posedge clk);
	endtask

	task automatic add_cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		stim_row_t row;
		row.kind  = ROW_CFG;
		row.index = idx;
		row.value = val;
		row.typed = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_smp_row(input logic [SMP_W-1:0] s, input bit typed,
			input alarm_result_t want);
		stim_row_t row;
		row.kind  = ROW_SAMPLE;
		row.index = REG_CHANGE_THR;
		row.value = s;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// random register set; extremes and crossed limits now and then
	task automatic random_config();
		logic [LIM_W-1:0] warn;
		logic [LIM_W-1:0] danger;
		case ($urandom_range(5))
			0:       write_reg(REG_CHANGE_THR, '0);
			1:       write_reg(REG_CHANGE_THR, '1);
			default: write_reg(REG_CHANGE_THR, CFG_DAT_W'($urandom_range(20, 400)));
		endcase
		warn   = LIM_W'($urandom_range(0, 3600));
		danger = warn + LIM_W'($urandom_range(0, 800));
		if (danger < warn)
			danger = '1;
		case ($urandom_range(7))
			0: begin warn = '0; danger = '1; end
			1: begin warn = '1; danger = '0; end
			2: begin danger = LIM_W'($urandom_range(0, 4095)); end
			default: ;
		endcase
		write_reg(REG_WARN_LIM, warn);
		write_reg(REG_DANGER_LIM, danger);
		write_reg(REG_SYS_MODE, CFG_DAT_W'($urandom_range(0, 3)));
	endtask

	// next sample: mostly drift around a level, with jumps, extremes and repeats
	function automatic logic [SMP_W-1:0] next_sample(inout int level);
		int pick;
		int lim;
		pick = int'($urandom_range(99));
		lim  = (thr_reg > 0) ? int'(thr_reg) : 1;
		if (pick < 55)
			level = level + int'($urandom_range(0, 2 * lim)) - lim;
		else if (pick < 70)
			level = int'($urandom_range(0, 4095));
		else if (pick < 80)
			level = $urandom_range(1) ? 4095 : 0;
		else if (pick < 85)
			level = level + ($urandom_range(1) ? lim + 1 : -(lim + 1));
		if (level < 0)
			level = 0;
		if (level > 4095)
			level = 4095;
		return SMP_W'(level);
	endfunction

	// timeout
	initial begin
		#50_000_000;
		$display("adaptive_window_average_alarm_top: mismatch");
		$finish;
	end

	// stimulus
	initial begin
		int level;
		arst_n       = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CHANGE_THR;
		cfg_ch.data  = '0;
		res_ch.ready = 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		mismatch_cnt = 0;
		model_last   = '0;
		foreach (history[i])
			history[i] = '0;
		thr_reg    = CHANGE_THR_RST;
		warn_reg   = WARN_LIM_RST;
		danger_reg = DANGER_LIM_RST;
		mode_reg   = MODE_AUTO;

		// directed table: reset state, window switch, every mode, limit extremes
		add_smp_row(12'd0,    1'b1,
			'{12'd0,    5'd16, CLS_NORMAL, DRIVE_NORMAL, 1'b0, 1'b1, 1'b0});
		add_smp_row(12'd4095, 1'b1,
			'{12'd2047, 5'd2,  CLS_DANGER, DRIVE_DANGER, 1'b1, 1'b0, 1'b1});
		add_smp_row(12'd4095, 1'b1,
			'{12'd511,  5'd16, CLS_DANGER, DRIVE_DANGER, 1'b1, 1'b0, 1'b1});
		add_cfg_row(REG_SYS_MODE, CFG_DAT_W'(MODE_MANUAL));
		add_smp_row(12'd4095, 1'b0, '0);
		add_smp_row(12'd400,  1'b0, '0);
		// long window after a short one picks up the stale tail
		add_smp_row(12'd410,  1'b0, '0);
		add_cfg_row(REG_SYS_MODE, CFG_DAT_W'(MODE_SAFE));
		add_smp_row(12'd380,  1'b0, '0);
		add_cfg_row(REG_SYS_MODE, CFG_DAT_W'(MODE_UNUSED));
		add_smp_row(12'd500,  1'b0, '0);
		add_cfg_row(REG_SYS_MODE, CFG_DAT_W'(MODE_AUTO));
		add_cfg_row(REG_CHANGE_THR, 12'd0);
		add_smp_row(12'd501,  1'b0, '0);
		add_smp_row(12'd501,  1'b0, '0);
		add_cfg_row(REG_CHANGE_THR, 12'd4095);
		add_smp_row(12'd0,    1'b0, '0);
		add_smp_row(12'd4095, 1'b0, '0);
		// warning limit above danger limit
		add_cfg_row(REG_WARN_LIM, 12'd1000);
		add_cfg_row(REG_DANGER_LIM, 12'd500);
		add_smp_row(12'd700,  1'b0, '0);
		add_smp_row(12'd1200, 1'b0, '0);
		add_smp_row(12'd4095, 1'b0, '0);
		add_cfg_row(REG_WARN_LIM, 12'd0);
		add_cfg_row(REG_DANGER_LIM, 12'd4095);
		add_smp_row(12'd4095, 1'b0, '0);
		add_smp_row(12'd4095, 1'b0, '0);
		add_smp_row(12'd1,    1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].index, directed_rows[i].value);
			else
				send_sample(directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].want);
		end

		// random streams: mostly receiver stalls, then mostly sender stalls, then neither
		level = 0;
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 73 : 0;
			rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 32 : 0;
			for (int blk = 0; blk < 6; blk++) begin
				random_config();
				for (int n = 0; n < 105; n++)
					send_sample(next_sample(level), 1'b0, '0);
			end
		end

		drain_results();
		repeat (64) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("adaptive_window_average_alarm_top: match");
		else
			$display("adaptive_window_average_alarm_top: mismatch");
		$finish;
	end

endmodule

[filelist.f]
rtl/awa_pkg.sv
rtl/awa_if.sv
rtl/adaptive_window_average_alarm_top.sv
test/tb_adaptive_window_average_alarm_top.sv
